// ===== rtl/fpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsc_pkg
// shared constants, register and request codes, and the command and status
// bundles between the sequencer and the datapath of the frame slot cache
// ----------------------------------------------------------------------------
package fpsc_pkg;

	localparam int SLOTS_DEF      = 32;
	localparam int MAX_FRAMES_DEF = 4096;

	// register field widths
	localparam int FT_W   = 13;
	localparam int SC_W   = 6;
	localparam int FD_W   = 13;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 13;

	// result field widths
	localparam int FRAME_OW = 12;
	localparam int SLOT_OW  = 5;
	localparam int BYTES_W  = 32;
	localparam int TIME_W   = 32;
	localparam int REQ_W    = 2;

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_FRAME_TOTAL  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_SLOT_COUNT   = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_PLAYING      = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 3'd4;

	// register reset values
	localparam logic [FT_W-1:0] FRAME_TOTAL_RST  = 13'd1;
	localparam logic [SC_W-1:0] SLOT_COUNT_RST   = 6'd20;
	localparam logic            PLAYING_RST      = 1'b1;
	localparam logic [FD_W-1:0] FRAME_WIDTH_RST  = 13'd32;
	localparam logic [FD_W-1:0] FRAME_HEIGHT_RST = 13'd32;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACCESS  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

	typedef struct packed {
		logic start;
		logic rem_start;
		logic rem_take;
		logic prep;
		logic match;
		logic decide;
		logic accum;
		logic emit;
	} fpsc_cmd_t;

	typedef struct packed {
		logic rem_needed;
		logic rem_done;
		logic search;
		logic found;
	} fpsc_stat_t;

endpackage

// ===== rtl/fpsc_rem.sv =====
// ----------------------------------------------------------------------------
// fpsc_rem
// restoring remainder unit, one dividend bit per cycle, used to bring the
// current frame back inside the frame total after the total has shrunk
// ----------------------------------------------------------------------------
module fpsc_rem #(
	parameter int FW = 12,
	parameter int TW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [FW-1:0] dividend,
	input  logic [TW-1:0] divisor,
	output logic          done,
	output logic [FW-1:0] rem
);

	localparam int CW = $clog2(FW + 1);

	logic [TW-1:0] r_q;
	logic [TW-1:0] d_q;
	logic [FW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [TW:0]   trial_c;
	logic [TW-1:0] r_next_c;

	always_comb begin
		trial_c = {r_q, q_q[FW-1]};
		if (trial_c >= {1'b0, d_q}) begin
			r_next_c = TW'(trial_c - {1'b0, d_q});
		end else begin
			r_next_c = TW'(trial_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(FW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= r_next_c;
			q_q <= q_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = FW'(r_q);

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < d_q))
		else $error("remainder not below divisor");

endmodule

// ===== rtl/fpsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpsc_ctrl
// sequencer: takes one request at a time, steps the datapath through
// reduction, preparation, slot match, decision and byte accounting, and
// holds the result transfer until the consumer takes it
// ----------------------------------------------------------------------------
module fpsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  fpsc_pkg::fpsc_stat_t  stat,
	output fpsc_pkg::fpsc_cmd_t   cmd
);

	import fpsc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MOD    = 7'b0000010,
		ST_PREP   = 7'b0000100,
		ST_MATCH  = 7'b0001000,
		ST_DECIDE = 7'b0010000,
		ST_ACCUM  = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					if (stat.rem_needed) begin
						cmd.rem_start = 1'b1;
						state_d       = ST_MOD;
					end else begin
						state_d = ST_PREP;
					end
				end
			end
			ST_MOD: begin
				if (stat.rem_done) begin
					cmd.rem_take = 1'b1;
					state_d      = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.search ? ST_MATCH : ST_EMIT;
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.found ? ST_EMIT : ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_emit_after_prep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result raised outside the emit step");

endmodule

// ===== rtl/fpsc_dpath.sv =====
// ----------------------------------------------------------------------------
// fpsc_dpath
// datapath: configuration registers, slot row with per-slot frame compare,
// fifo replacement pointer, frame counter, byte accounting and result register
// ----------------------------------------------------------------------------
module fpsc_dpath #(
	parameter int SLOTS      = 32,
	parameter int MAX_FRAMES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpsc_pkg::CFG_AW-1:0]         cfg_addr,
	input  logic [fpsc_pkg::CFG_DW-1:0]         cfg_wdata,
	input  logic [fpsc_pkg::REQ_W-1:0]          req_type,
	input  logic [fpsc_pkg::TIME_W-1:0]         now_ms,
	input  logic [fpsc_pkg::TIME_W-1:0]         frame_duration,
	input  fpsc_pkg::fpsc_cmd_t                 cmd,
	output fpsc_pkg::fpsc_stat_t                stat,
	output logic [fpsc_pkg::FRAME_OW-1:0]       shown_frame,
	output logic                                advanced,
	output logic [fpsc_pkg::SLOT_OW-1:0]        hit_slot,
	output logic                                access_hit,
	output logic                                loaded,
	output logic [fpsc_pkg::SLOT_OW-1:0]        load_slot,
	output logic [fpsc_pkg::FRAME_OW-1:0]       load_frame,
	output logic                                evicted,
	output logic [fpsc_pkg::BYTES_W-1:0]        bytes_used
);

	import fpsc_pkg::*;

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int TW = $clog2(MAX_FRAMES + 1);
	localparam int AW = TW + 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = $clog2(SLOTS + 1);
	localparam int MW = (TW > SC_W) ? TW : SC_W;

	// configuration
	logic [FT_W-1:0] ft_q;
	logic [SC_W-1:0] sc_q;
	logic            play_q;
	logic [FD_W-1:0] fw_q;
	logic [FD_W-1:0] fh_q;

	// state
	logic [SLOTS-1:0] slot_valid_q;
	logic [FW-1:0]    slot_frame_q [SLOTS];
	logic [SW-1:0]    head_q;
	logic [FW-1:0]    frame_now_q;
	logic [TIME_W-1:0] last_q;
	logic [BYTES_W-1:0] bytes_q;

	// working registers
	logic [REQ_W-1:0]   req_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  dur_q;
	logic [FW-1:0]      key_q;
	logic [SLOTS-1:0]   match_q;
	logic [BYTES_W-1:0] fb_q;
	logic               adv_q;
	logic [SW-1:0]      hslot_q;
	logic               hit_q;
	logic               ld_q;
	logic [SW-1:0]      lslot_q;
	logic [FW-1:0]      lframe_q;
	logic               ev_q;

	// result register
	logic [FRAME_OW-1:0] shown_frame_q;
	logic                advanced_q;
	logic [SLOT_OW-1:0]  hit_slot_q;
	logic                access_hit_q;
	logic                loaded_q;
	logic [SLOT_OW-1:0]  load_slot_q;
	logic [FRAME_OW-1:0] load_frame_q;
	logic                evicted_q;
	logic [BYTES_W-1:0]  bytes_used_q;

	logic [TW-1:0]       total_c;
	logic [MW-1:0]       min_c;
	logic [NW-1:0]       n_c;
	logic [TIME_W-1:0]   elapsed_c;
	logic                tick_go_c;
	logic [AW-1:0]       fn1w_c;
	logic [FW-1:0]       fn1_c;
	logic [AW-1:0]       sum_c;
	logic [FW-1:0]       key_tick_c;
	logic                found_c;
	logic [SW-1:0]       found_idx_c;
	logic [SW-1:0]       victim_c;
	logic [NW-1:0]       victim_inc_c;
	logic [SW-1:0]       head_next_c;
	logic                load_c;
	logic [2*FD_W-1:0]   wh_c;
	logic                rem_done;
	logic [FW-1:0]       rem_res;

	// effective frame total and used slot count
	always_comb begin
		if (ft_q == '0) begin
			total_c = TW'(1);
		end else if (32'(ft_q) > MAX_FRAMES) begin
			total_c = TW'(MAX_FRAMES);
		end else begin
			total_c = TW'(ft_q);
		end
		if (MW'(sc_q) > MW'(total_c)) begin
			min_c = MW'(total_c);
		end else begin
			min_c = MW'(sc_q);
		end
		if (sc_q == '0) begin
			n_c = NW'(1);
		end else if (32'(min_c) > SLOTS) begin
			n_c = NW'(SLOTS);
		end else begin
			n_c = NW'(min_c);
		end
	end

	// tick: advance and the frame one slot row ahead
	always_comb begin
		elapsed_c = now_q - last_q;
		tick_go_c = play_q && (total_c > TW'(1)) && (elapsed_c >= dur_q);
		fn1w_c    = AW'(frame_now_q) + AW'(1);
		fn1_c     = (fn1w_c >= AW'(total_c)) ? '0 : FW'(fn1w_c);
		sum_c     = AW'(fn1_c) + AW'(n_c);
		if (sum_c >= AW'(total_c)) begin
			key_tick_c = FW'(sum_c - AW'(total_c));
		end else begin
			key_tick_c = FW'(sum_c);
		end
	end

	// lowest matching slot wins, as stale copies may sit beyond a shrunk row
	always_comb begin
		found_idx_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				found_idx_c = SW'(i);
			end
		end
		found_c = |match_q;
	end

	always_comb begin
		victim_c     = (NW'(head_q) < n_c) ? head_q : '0;
		victim_inc_c = NW'(victim_c) + NW'(1);
		head_next_c  = (victim_inc_c == n_c) ? '0 : SW'(victim_inc_c);
		load_c       = cmd.decide && !found_c;
	end

	assign wh_c = fw_q * fh_q;

	fpsc_rem #(
		.FW (FW),
		.TW (TW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.dividend (frame_now_q),
		.divisor  (total_c),
		.done     (rem_done),
		.rem      (rem_res)
	);

	always_comb begin
		stat.rem_needed = (AW'(frame_now_q) >= AW'(total_c));
		stat.rem_done   = rem_done;
		stat.search     = ((req_q == REQ_TICK) && tick_go_c) || (req_q == REQ_ACCESS);
		stat.found      = found_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q   <= FRAME_TOTAL_RST;
			sc_q   <= SLOT_COUNT_RST;
			play_q <= PLAYING_RST;
			fw_q   <= FRAME_WIDTH_RST;
			fh_q   <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FRAME_TOTAL:  ft_q   <= cfg_wdata[FT_W-1:0];
				CFG_SLOT_COUNT:   sc_q   <= cfg_wdata[SC_W-1:0];
				CFG_PLAYING:      play_q <= cfg_wdata[0];
				CFG_FRAME_WIDTH:  fw_q   <= cfg_wdata[FD_W-1:0];
				CFG_FRAME_HEIGHT: fh_q   <= cfg_wdata[FD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			head_q       <= '0;
			frame_now_q  <= '0;
			last_q       <= '0;
			bytes_q      <= '0;
		end else begin
			if (cmd.rem_take) begin
				frame_now_q <= rem_res;
			end
			if (cmd.prep) begin
				case (req_q)
					REQ_TICK: begin
						if (tick_go_c) begin
							frame_now_q <= fn1_c;
							last_q      <= now_q;
						end
					end
					REQ_RESTART: begin
						frame_now_q <= '0;
						last_q      <= '0;
					end
					default: begin
					end
				endcase
			end
			if (load_c) begin
				head_q                 <= head_next_c;
				slot_valid_q[victim_c] <= 1'b1;
				if (slot_valid_q[victim_c]) begin
					bytes_q <= (bytes_q >= fb_q) ? bytes_q - fb_q : '0;
				end
			end
			if (cmd.accum) begin
				// saturate at the top of the byte count
				bytes_q <= (bytes_q > ~fb_q) ? '1 : bytes_q + fb_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			slot_frame_q[victim_c] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		// four bytes per pixel
		fb_q <= BYTES_W'({wh_c, 2'b00});
		if (cmd.start) begin
			req_q    <= req_type;
			now_q    <= now_ms;
			dur_q    <= frame_duration;
			adv_q    <= 1'b0;
			hslot_q  <= '0;
			hit_q    <= 1'b0;
			ld_q     <= 1'b0;
			lslot_q  <= '0;
			lframe_q <= '0;
			ev_q     <= 1'b0;
		end
		if (cmd.prep) begin
			case (req_q)
				REQ_TICK: begin
					if (tick_go_c) begin
						adv_q <= 1'b1;
						key_q <= key_tick_c;
					end
				end
				REQ_ACCESS: key_q <= frame_now_q;
				default: begin
				end
			endcase
		end
		if (cmd.match) begin
			for (int i = 0; i < SLOTS; i++) begin
				match_q[i] <= slot_valid_q[i] && (slot_frame_q[i] == key_q) &&
					(NW'(i) < n_c);
			end
		end
		if (cmd.decide && found_c && (req_q == REQ_ACCESS)) begin
			hit_q   <= 1'b1;
			hslot_q <= found_idx_c;
		end
		if (load_c) begin
			ld_q     <= 1'b1;
			lslot_q  <= victim_c;
			lframe_q <= key_q;
			ev_q     <= slot_valid_q[victim_c];
			if (req_q == REQ_ACCESS) begin
				hslot_q <= victim_c;
			end
		end
		if (cmd.emit) begin
			shown_frame_q <= FRAME_OW'(frame_now_q);
			advanced_q    <= adv_q;
			hit_slot_q    <= SLOT_OW'(hslot_q);
			access_hit_q  <= hit_q;
			loaded_q      <= ld_q;
			load_slot_q   <= SLOT_OW'(lslot_q);
			load_frame_q  <= FRAME_OW'(lframe_q);
			evicted_q     <= ev_q;
			bytes_used_q  <= bytes_q;
		end
	end

	assign shown_frame = shown_frame_q;
	assign advanced    = advanced_q;
	assign hit_slot    = hit_slot_q;
	assign access_hit  = access_hit_q;
	assign loaded      = loaded_q;
	assign load_slot   = load_slot_q;
	assign load_frame  = load_frame_q;
	assign evicted     = evicted_q;
	assign bytes_used  = bytes_used_q;

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |-> (AW'(frame_now_q) < AW'(total_c)))
		else $error("current frame not reduced before preparation");

	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		load_c |=> (slot_valid_q[$past(victim_c)] &&
			(slot_frame_q[$past(victim_c)] == $past(key_q))))
		else $error("replaced slot does not hold the loaded frame");

	a_accum_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum |=> (bytes_q >= $past(bytes_q)))
		else $error("byte count fell on an add");

endmodule

// ===== rtl/frame_prefetch_slot_cache_unit.sv =====
// ----------------------------------------------------------------------------
// frame_prefetch_slot_cache_unit
// playback cache for one looping animation with fifo slot replacement
// ----------------------------------------------------------------------------
// One request is handled at a time; the block stalls its input from the
// transfer until the result has been placed in the output register. A
// restart, an unknown request or a tick that does not advance goes from
// preparation straight to the result; when the looked-up frame is resident
// (tick prefetch already present, or access hit) the sequencer also steps
// through a registered compare of every slot and the replacement decision,
// and when a slot is replaced it adds a separate saturating byte add. When
// frame_total has been lowered below the current frame, the first request
// afterwards first passes through the bit-serial remainder unit. Slot valid
// marks clear at reset, so no clearing pass is needed.
module frame_prefetch_slot_cache_unit #(
	parameter int SLOTS      = fpsc_pkg::SLOTS_DEF,
	parameter int MAX_FRAMES = fpsc_pkg::MAX_FRAMES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpsc_pkg::CFG_AW-1:0]         cfg_addr,
	input  logic [fpsc_pkg::CFG_DW-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fpsc_pkg::REQ_W-1:0]          req_type,
	input  logic [fpsc_pkg::TIME_W-1:0]         now_ms,
	input  logic [fpsc_pkg::TIME_W-1:0]         frame_duration,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fpsc_pkg::FRAME_OW-1:0]       shown_frame,
	output logic                                advanced,
	output logic [fpsc_pkg::SLOT_OW-1:0]        hit_slot,
	output logic                                access_hit,
	output logic                                loaded,
	output logic [fpsc_pkg::SLOT_OW-1:0]        load_slot,
	output logic [fpsc_pkg::FRAME_OW-1:0]       load_frame,
	output logic                                evicted,
	output logic [fpsc_pkg::BYTES_W-1:0]        bytes_used
);

	import fpsc_pkg::*;

	fpsc_cmd_t  cmd;
	fpsc_stat_t stat;

	fpsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fpsc_dpath #(
		.SLOTS      (SLOTS),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.req_type       (req_type),
		.now_ms         (now_ms),
		.frame_duration (frame_duration),
		.cmd            (cmd),
		.stat           (stat),
		.shown_frame    (shown_frame),
		.advanced       (advanced),
		.hit_slot       (hit_slot),
		.access_hit     (access_hit),
		.loaded         (loaded),
		.load_slot      (load_slot),
		.load_frame     (load_frame),
		.evicted        (evicted),
		.bytes_used     (bytes_used)
	);

endmodule
